@@ rtl/core/olarv_pkg.sv @@
// shared constants, codes and types for the ordered list unit
package olarv_pkg;

   // store geometry
   localparam int CAPACITY = 32;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   // op codes carried on the input word
   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // status codes carried on the result word
   localparam logic [2:0] STAT_DONE     = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_NOTFOUND = 3'd2;
   localparam logic [2:0] STAT_EMPTY    = 3'd3;
   localparam logic [2:0] STAT_ENTRY    = 3'd4;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic              append;
      logic              remove;
      logic              rotate;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  count;
   } cmd_type;

endpackage

@@ rtl/core/olarv_cell.sv @@
// one slot of the list: holds an entry and shifts it towards the head
module olarv_cell (
   input  logic                        clock,
   input  logic [olarv_pkg::IDX_W-1:0] cell_index,
   input  olarv_pkg::cmd_type          cmd,
   input  logic [olarv_pkg::DATA_W-1:0] head_entry,
   input  logic [olarv_pkg::DATA_W-1:0] next_entry,
   input  logic                        found_before,
   output logic [olarv_pkg::DATA_W-1:0] entry,
   output logic                        found_through
);
   import olarv_pkg::*;

   logic [DATA_W-1:0] entry_ff;
   logic [DATA_W-1:0] entry_in;
   logic [CNT_W-1:0]  my_pos;
   logic              in_use;
   logic              is_tail;
   logic              is_free_slot;
   logic              match;

   // position of this slot against the fill count
   assign my_pos       = CNT_W'(cell_index);
   assign in_use       = my_pos < cmd.count;
   assign is_tail      = my_pos == (cmd.count - CNT_W'(1));
   assign is_free_slot = my_pos == cmd.count;

   // first-match search ripples from the head
   assign match         = in_use && (entry_ff == cmd.value);
   assign found_through = found_before | match;

   // next entry: append writes the free slot, remove closes the gap,
   // readout rotates the occupied part by one
   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.append && is_free_slot) begin
         entry_in = cmd.value;
      end else if (cmd.remove && in_use && found_through) begin
         entry_in = next_entry;
      end else if (cmd.rotate && in_use) begin
         entry_in = is_tail ? head_entry : next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

@@ rtl/core/ordered_list_append_remove_value_unit.sv @@
// Ordered list of signed 32-bit values held in a row of 32 cells, head in cell 0.
// Append writes the free cell after the tail; on remove all cells compare the
// value at once, the first match is found along a one-bit chain and the later cells
// shift one place towards the head. Readout of n entries first takes the request,
// then gives one word per cycle while the result register is free: the occupied
// cells rotate by one and the head cell supplies the word, so after the run the list
// stands as before. No input word is taken during a readout. Append to a full list
// returns status full, remove without a match returns not found, readout of an empty
// list returns one word with status empty. The result register lets a new input word
// in while the previous result is being taken.
module ordered_list_append_remove_value_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic signed [olarv_pkg::DATA_W-1:0] req_tdata,  // value
   input  logic [1:0]                          req_tuser,  // op
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [olarv_pkg::DATA_W-1:0] rsp_tdata,  // data
   output logic [2:0]                          rsp_tuser,  // status
   output logic                                rsp_tlast
);
   import olarv_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_READ = 1'b1;

   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_stat_ff, rsp_stat_in;
   logic              rsp_last_ff, rsp_last_in;

   cmd_type           cmd;
   logic              out_free;
   logic              accept;
   logic              full;
   logic              read_step;
   logic              read_end;
   logic [DATA_W-1:0] cell_entry [CAPACITY];
   logic [CAPACITY:0] found_chain;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == STATE_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign read_step  = (state_ff == STATE_READ) && out_free;
   assign read_end   = rd_idx_ff == (count_ff - CNT_W'(1));

   // command to the cells
   always_comb begin
      cmd.append = accept && (req_tuser == OP_APPEND) && !full;
      cmd.remove = accept && (req_tuser == OP_REMOVE);
      cmd.rotate = read_step;
      cmd.value  = req_tdata;
      cmd.count  = count_ff;
   end

   // chain of cells
   assign found_chain[0] = 1'b0;
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [DATA_W-1:0] next_entry;
      if (g == CAPACITY - 1) begin : g_end
         assign next_entry = cell_entry[g];
      end else begin : g_mid
         assign next_entry = cell_entry[g+1];
      end
      olarv_cell u_cell (
         .clock         (clock),
         .cell_index    (IDX_W'(g)),
         .cmd           (cmd),
         .head_entry    (cell_entry[0]),
         .next_entry    (next_entry),
         .found_before  (found_chain[g]),
         .entry         (cell_entry[g]),
         .found_through (found_chain[g+1])
      );
   end

   // control and result register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_last_in  = 1'b1;
         rsp_stat_in  = STAT_DONE;
         unique case (req_tuser)
            OP_APPEND: begin
               if (full) begin
                  rsp_stat_in = STAT_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (found_chain[CAPACITY]) begin
                  count_in = count_ff - CNT_W'(1);
               end else begin
                  rsp_stat_in = STAT_NOTFOUND;
               end
            end
            OP_READ: begin
               if (count_ff == '0) begin
                  rsp_stat_in = STAT_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = STATE_READ;
                  rd_idx_in    = '0;
               end
            end
            default: begin
               rsp_stat_in = STAT_DONE;
            end
         endcase
      end else if (read_step) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = cell_entry[0];
         rsp_stat_in  = STAT_ENTRY;
         rsp_last_in  = read_end;
         rd_idx_in    = rd_idx_ff + CNT_W'(1);
         if (read_end) begin
            state_in = STATE_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_read_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_READ) |-> (count_ff != '0))
      else $error("readout running on an empty list");

   a_read_no_take : assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_READ) |-> !req_tready)
      else $error("input word taken during readout");

   a_append_grows : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == OP_APPEND) && !full)
         |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow the list");

   a_read_idx : assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_READ) |-> (rd_idx_ff < count_ff))
      else $error("readout index past the tail");

endmodule

@@ dv/tb_top.sv @@
// self-checking testbench for the ordered list unit: stream stimulus, shadow list and word checks
module tb_top;
   import olarv_pkg::*;

   localparam int  CYCLE_LIMIT = 1000000;
   localparam int  DRAIN_WAIT  = 40;
   localparam int  STALL_LEN   = 300;
   localparam int  REPORT_MAX  = 10;
   // op code left unused by the block, answered with a plain done word
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct {
      logic signed [DATA_W-1:0] data;
      logic [2:0]               status;
      logic                     last;
   } rsp_word_type;

   // shadow copy of the list and the words it is owed
   class list_shadow;
      logic signed [DATA_W-1:0] slots [CAPACITY];
      int                       fill;
      rsp_word_type             due_words [$];
      int                       bad_words;

      function new();
         fill      = 0;
         bad_words = 0;
      endfunction

      function void push_word(logic signed [DATA_W-1:0] d, logic [2:0] s, logic l);
         rsp_word_type w;
         w.data   = d;
         w.status = s;
         w.last   = l;
         due_words.push_back(w);
      endfunction

      // work out the words that one accepted request word causes
      function void apply_op(logic [1:0] op, logic signed [DATA_W-1:0] value);
         int hit;
         int i;
         hit = -1;
         case (op)
            OP_APPEND: begin
               if (fill >= CAPACITY) begin
                  push_word('0, STAT_FULL, 1'b1);
               end else begin
                  slots[fill] = value;
                  fill++;
                  push_word('0, STAT_DONE, 1'b1);
               end
            end
            OP_REMOVE: begin
               for (i = 0; i < fill; i++) begin
                  if (hit < 0 && slots[i] == value) hit = i;
               end
               if (hit < 0) begin
                  push_word('0, STAT_NOTFOUND, 1'b1);
               end else begin
                  // close the gap, keeping order
                  for (i = hit; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
                  push_word('0, STAT_DONE, 1'b1);
               end
            end
            OP_READ: begin
               if (fill == 0) begin
                  push_word('0, STAT_EMPTY, 1'b1);
               end else begin
                  for (i = 0; i < fill; i++) push_word(slots[i], STAT_ENTRY, i == fill - 1);
               end
            end
            default: begin
               push_word('0, STAT_DONE, 1'b1);
            end
         endcase
      endfunction

      // compare one accepted response word with the oldest owed word
      function void check_word(logic signed [DATA_W-1:0] d, logic [2:0] s, logic l);
         rsp_word_type w;
         if (due_words.size() == 0) begin
            bad_words++;
            if (bad_words <= REPORT_MAX)
               $display("unexpected word: data %0d status %0d last %0b", d, s, l);
         end else begin
            w = due_words.pop_front();
            if (w.data !== d || w.status !== s || w.last !== l) begin
               bad_words++;
               if (bad_words <= REPORT_MAX)
                  $display({"wrong word: expected data %0d status %0d last %0b,",
                            " got data %0d status %0d last %0b"},
                           w.data, w.status, w.last, d, s, l);
            end
         end
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic signed [DATA_W-1:0] req_tdata  = '0;           // value
   logic [1:0]               req_tuser  = OP_APPEND;    // op
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic signed [DATA_W-1:0] rsp_tdata;                 // data
   logic [2:0]               rsp_tuser;                 // status
   logic                     rsp_tlast;

   list_shadow shadow = new();
   int         tx_idle_pct = 11;
   int         rx_idle_pct = 78;
   int         stall_left  = 0;
   int         cycle_cnt   = 0;

   ordered_list_append_remove_value_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("ordered_list_append_remove_value_unit: mismatch");
         $finish;
      end
   end

   // observe both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) shadow.apply_op(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) shadow.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // receiver: random back-pressure, or a long hold-off when asked
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // offer one request word and hold it until taken
   task automatic send_word(input logic [1:0] op, input logic signed [DATA_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait until every owed word has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.due_words.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // mostly small values so that duplicates occur, some extremes, the rest anything
   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(9);
      if (r < 4) return $signed($urandom_range(6)) - 3;
      if (r == 4) return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      return $urandom;
   endfunction

   // random traffic steered towards a fill level that changes every episode
   task automatic run_random(input int n, input bit start_full);
      int                       k;
      int                       r;
      int                       target;
      logic signed [DATA_W-1:0] v;
      target = start_full ? CAPACITY + 4 : $urandom_range(CAPACITY);
      for (k = 0; k < n; k++) begin
         if (k > 0 && k % 60 == 0) target = $urandom_range(CAPACITY + 4);
         r = $urandom_range(99);
         if (r < 10) begin
            send_word(OP_READ, $urandom);
         end else if (r < 10 + ((shadow.fill < target) ? 75 : 20)) begin
            send_word(OP_APPEND, pick_value());
         end else begin
            // mostly remove something that is held, sometimes a likely miss
            if (shadow.fill > 0 && $urandom_range(99) < 75)
               v = shadow.slots[$urandom_range(shadow.fill - 1)];
            else
               v = pick_value();
            send_word(OP_REMOVE, v);
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty cases, extremes, duplicates, head, tail and spare op
      send_word(OP_READ,   32'sd0);
      send_word(OP_REMOVE, 32'sd5);
      send_word(OP_APPEND, 32'sh7FFFFFFF);
      send_word(OP_APPEND, 32'sh80000000);
      send_word(OP_APPEND, -32'sd1);
      send_word(OP_APPEND, 32'sd0);
      send_word(OP_APPEND, 32'sd7);
      send_word(OP_APPEND, 32'sd7);
      send_word(OP_APPEND, -32'sd1);
      send_word(OP_READ,   -32'sd1);
      send_word(OP_REMOVE, 32'sd7);
      send_word(OP_REMOVE, 32'sd123);
      send_word(OP_REMOVE, 32'sh7FFFFFFF);
      send_word(OP_REMOVE, -32'sd1);
      send_word(OP_READ,   32'sh55555555);
      send_word(OP_SPARE,  -32'sd1);
      send_word(OP_REMOVE, -32'sd1);
      send_word(OP_REMOVE, 32'sd0);
      send_word(OP_REMOVE, 32'sd7);
      send_word(OP_REMOVE, 32'sh80000000);
      send_word(OP_READ,   32'shAAAAAAAA);
      send_word(OP_APPEND, 32'sh55555555);
      send_word(OP_APPEND, 32'shAAAAAAAA);
      send_word(OP_READ,   32'sd0);

      // first random phase: sender rarely idle, receiver mostly stalled
      run_random(150, 1'b1);
      wait_drained();

      // second random phase: the other way round
      tx_idle_pct = 78;
      rx_idle_pct = 11;
      run_random(150, 1'b0);
      wait_drained();

      // third phase: no idling, opening with a long receiver hold-off
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      @(posedge clock);
      stall_left = STALL_LEN;
      @(negedge clock);
      run_random(146, 1'b1);
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (shadow.bad_words == 0 && shadow.due_words.size() == 0) begin
         $display("ordered_list_append_remove_value_unit: match");
      end else begin
         $display("ordered_list_append_remove_value_unit: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/olarv_pkg.sv
rtl/core/olarv_cell.sv
rtl/core/ordered_list_append_remove_value_unit.sv
dv/tb_top.sv
